// ----- rtl/core/slap_pkg.sv -----
// ----------------------------------------------------------------------------
// slap_pkg
// Shared constants, types and codes of the sign-data LMS predictor.
// ----------------------------------------------------------------------------
package slap_pkg;

	localparam int TAPS        = 4;
	localparam int LANE_W      = 16;
	localparam int WT_W        = 32;
	localparam int PACK_W      = TAPS * LANE_W;
	localparam int RES_W       = 32;
	localparam int PRED_W      = 19;
	localparam int PRED_SHIFT  = 13;
	localparam int ADAPT_SHIFT = 4;
	localparam int PROD_W      = LANE_W + WT_W;
	// pending, product, one stage per accumulate cell, output
	localparam int STAGES      = TAPS + 3;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_UPDATE = 1'b1;

	typedef logic signed [LANE_W-1:0] lane_t;
	typedef logic signed [WT_W-1:0]   wt_t;
	typedef wt_t [TAPS-1:0]           wt_vec_t;

	typedef struct packed {
		logic load;
		logic update;
		logic capture;
	} tap_ctl_t;

endpackage

// ----- rtl/core/slap_if.sv -----
// ----------------------------------------------------------------------------
// slap_in_if / slap_out_if
// Valid/ready channels carrying command words in and predictions out.
// ----------------------------------------------------------------------------
interface slap_in_if;
	import slap_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     command;
	logic [PACK_W-1:0]        hist_lanes;
	logic [PACK_W-1:0]        wt_lanes;
	logic signed [LANE_W-1:0] new_sample;
	logic signed [RES_W-1:0]  residual;

	modport source (
		output valid, command, hist_lanes, wt_lanes, new_sample, residual,
		input  ready
	);
	modport sink (
		input  valid, command, hist_lanes, wt_lanes, new_sample, residual,
		output ready
	);
endinterface

interface slap_out_if;
	import slap_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [PRED_W-1:0] prediction;

	modport source (
		output valid, prediction,
		input  ready
	);
	modport sink (
		input  valid, prediction,
		output ready
	);
endinterface

// ----- rtl/core/slap_tap.sv -----
// ----------------------------------------------------------------------------
// slap_tap
// One predictor tap: holds a history sample and its weight, adapts them,
// and registers the saturated product for the accumulate chain.
// ----------------------------------------------------------------------------
module slap_tap (
	input  logic             clk,
	input  logic             arst_n,
	input  slap_pkg::tap_ctl_t ctl,
	input  slap_pkg::lane_t  load_hist,
	input  slap_pkg::lane_t  load_wt,
	input  slap_pkg::lane_t  shift_in,
	input  slap_pkg::wt_t    delta,
	output slap_pkg::lane_t  hist,
	output slap_pkg::wt_t    prod
);
	import slap_pkg::*;

	lane_t                    hist_q;
	wt_t                      wt_q;
	wt_t                      prod_s1;
	logic signed [PROD_W-1:0] mult;
	wt_t                      mult_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
			wt_q   <= '0;
		end else if (ctl.load) begin
			hist_q <= load_hist;
			wt_q   <= WT_W'(load_wt);
		end else if (ctl.update) begin
			// adaptation uses the sign of the sample before the shift
			wt_q   <= hist_q[LANE_W-1] ? wt_q - delta : wt_q + delta;
			hist_q <= shift_in;
		end
	end

	assign mult = PROD_W'(hist_q) * PROD_W'(wt_q);

	always_comb begin
		if (mult[PROD_W-1:WT_W-1] == '0 || mult[PROD_W-1:WT_W-1] == '1) begin
			mult_sat = mult[WT_W-1:0];
		end else if (mult[PROD_W-1]) begin
			mult_sat = {1'b1, {(WT_W-1){1'b0}}};
		end else begin
			mult_sat = {1'b0, {(WT_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			prod_s1 <= mult_sat;
		end
	end

	assign hist = hist_q;
	assign prod = prod_s1;

endmodule

// ----- rtl/core/slap_acc.sv -----
// ----------------------------------------------------------------------------
// slap_acc
// Accumulate cell: adds the head of the product queue to the running sum
// with 32-bit saturation and hands the shortened queue to its neighbor.
// ----------------------------------------------------------------------------
module slap_acc (
	input  logic              clk,
	input  logic              load,
	input  slap_pkg::wt_t     acc_in,
	input  slap_pkg::wt_vec_t prods_in,
	output slap_pkg::wt_t     acc_out,
	output slap_pkg::wt_vec_t prods_out
);
	import slap_pkg::*;

	wt_t                    acc_s;
	wt_vec_t                prods_s;
	logic signed [WT_W:0]   sum;
	wt_t                    sum_sat;

	assign sum = {acc_in[WT_W-1], acc_in} + {prods_in[0][WT_W-1], prods_in[0]};

	always_comb begin
		if (sum[WT_W] == sum[WT_W-1]) begin
			sum_sat = sum[WT_W-1:0];
		end else if (sum[WT_W]) begin
			sum_sat = {1'b1, {(WT_W-1){1'b0}}};
		end else begin
			sum_sat = {1'b0, {(WT_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			acc_s   <= sum_sat;
			prods_s <= {{WT_W{1'b0}}, prods_in[TAPS-1:1]};
		end
	end

	assign acc_out   = acc_s;
	assign prods_out = prods_s;

endmodule

// ----- rtl/core/sign_lms_audio_predictor_unit.sv -----
// ----------------------------------------------------------------------------
// sign_lms_audio_predictor_unit
// Four-tap sign-data LMS predictor for one audio channel.
// ----------------------------------------------------------------------------
// Every accepted word (load of packed state, or update with a new sample and
// residual) yields exactly one prediction word. The tap state is updated at
// the accept edge; the prediction then runs through a row of four tap cells,
// each with its own 16x32 multiplier, and a row of four accumulate cells that
// add the saturated products in tap order ahead of the output register. A new
// word is taken every cycle: the pipeline stages collapse bubbles, so input
// keeps flowing while a finished prediction waits in the output register,
// until every stage is full.
// ----------------------------------------------------------------------------
module sign_lms_audio_predictor_unit (
	input logic       clk,
	input logic       arst_n,
	slap_in_if.sink   item,
	slap_out_if.source pred
);
	import slap_pkg::*;

	logic [STAGES-1:0] vld_q;
	logic [STAGES-1:0] en;
	logic              accept;
	tap_ctl_t          tap_ctl;
	wt_t               delta;
	lane_t             hist   [TAPS];
	wt_vec_t           prods;
	wt_t               acc_w  [TAPS+1];
	wt_vec_t           q_w    [TAPS];
	logic signed [PRED_W-1:0] pred_q;

	// a stage may load when it is empty or its contents move on
	always_comb begin
		en[STAGES-1] = !vld_q[STAGES-1] || pred.ready;
		for (int i = STAGES-2; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	assign item.ready = en[0];
	assign accept     = item.valid && en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= accept;
			end
			for (int i = 1; i < STAGES; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	assign tap_ctl.load    = accept && (item.command == CMD_LOAD);
	assign tap_ctl.update  = accept && (item.command == CMD_UPDATE);
	assign tap_ctl.capture = en[1] && vld_q[0];
	assign delta           = wt_t'(item.residual >>> ADAPT_SHIFT);

	genvar k;
	generate
		for (k = 0; k < TAPS; k++) begin : g_tap
			lane_t shift_in;
			if (k == TAPS-1) begin : g_last
				assign shift_in = item.new_sample;
			end else begin : g_mid
				assign shift_in = hist[k+1];
			end

			slap_tap u_tap (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (tap_ctl),
				.load_hist (lane_t'(item.hist_lanes[PACK_W-1-k*LANE_W -: LANE_W])),
				.load_wt   (lane_t'(item.wt_lanes[PACK_W-1-k*LANE_W -: LANE_W])),
				.shift_in  (shift_in),
				.delta     (delta),
				.hist      (hist[k]),
				.prod      (prods[k])
			);
		end
	endgenerate

	assign acc_w[0] = '0;
	assign q_w[0]   = prods;

	generate
		for (k = 0; k < TAPS; k++) begin : g_acc
			if (k == TAPS-1) begin : g_last
				slap_acc u_acc (
					.clk       (clk),
					.load      (en[k+2] && vld_q[k+1]),
					.acc_in    (acc_w[k]),
					.prods_in  (q_w[k]),
					.acc_out   (acc_w[k+1]),
					.prods_out ()
				);
			end else begin : g_mid
				slap_acc u_acc (
					.clk       (clk),
					.load      (en[k+2] && vld_q[k+1]),
					.acc_in    (acc_w[k]),
					.prods_in  (q_w[k]),
					.acc_out   (acc_w[k+1]),
					.prods_out (q_w[k+1])
				);
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en[STAGES-1] && vld_q[STAGES-2]) begin
			pred_q <= acc_w[TAPS][WT_W-1:PRED_SHIFT];
		end
	end

	assign pred.valid      = vld_q[STAGES-1];
	assign pred.prediction = pred_q;

`ifndef SYNTHESIS
	// input is refused only when every stage holds a word
	a_full_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> (&vld_q))
		else $error("input stalled with a bubble in the pipeline");

	a_load_oldest: assert property (@(posedge clk) disable iff (!arst_n)
		tap_ctl.load |=> hist[0] == $past(item.hist_lanes[PACK_W-1 -: LANE_W]))
		else $error("load did not place the oldest sample in tap 0");

	a_update_shift: assert property (@(posedge clk) disable iff (!arst_n)
		tap_ctl.update |=> (hist[TAPS-1] == $past(item.new_sample)) &&
			(hist[0] == $past(hist[1])))
		else $error("history shift on update went wrong");

	a_capture_once: assert property (@(posedge clk) disable iff (!arst_n)
		tap_ctl.capture |=> vld_q[1])
		else $error("captured products not marked valid");
`endif

endmodule
